### rtl/rgbrbc_pkg.sv
// Shared types, constants and helper functions for the RGB LED rainbow/blink controller.
// No dependencies; every other file imports this package.
package rgbrbc_pkg;

  localparam int COUNTER_BITS = 16;
  localparam int PERIOD_W     = 16;
  localparam int COLOR_W      = 24;
  localparam int CFG_IDX_W    = 1;
  localparam int CMP_W        = (COUNTER_BITS + 1 > PERIOD_W) ? COUNTER_BITS + 1 : PERIOD_W;

  localparam logic [PERIOD_W-1:0] GRADUAL_RESET = PERIOD_W'(10);
  localparam logic [PERIOD_W-1:0] FLICKER_RESET = PERIOD_W'(500);
  localparam logic [7:0]          WHEEL_STEP    = 8'd5;
  localparam logic [7:0]          CH_MAX        = 8'hFF;

  typedef logic [COUNTER_BITS-1:0] cnt_t;
  typedef logic [PERIOD_W-1:0]     period_t;

  typedef enum logic [2:0] {
    MODE_TICK       = 3'd0,
    MODE_SET_COLOR  = 3'd1,
    MODE_RAINBOW    = 3'd2,
    MODE_BLINK      = 3'd3,
    MODE_ALL_OFF    = 3'd4
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRADUAL = 1'b0,
    CFG_FLICKER = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic hit;
    cnt_t next;
  } cnt_step_t;

  // One period count: wraps to zero when the period is reached or the counter would overflow.
  function automatic cnt_step_t count_step(input cnt_t cnt, input period_t period);
    logic [COUNTER_BITS:0] inc;
    cnt_step_t             res;
    inc = {1'b0, cnt} + {{COUNTER_BITS{1'b0}}, 1'b1};
    res.hit  = (CMP_W'(inc) >= CMP_W'(period)) || inc[COUNTER_BITS];
    res.next = res.hit ? '0 : inc[COUNTER_BITS-1:0];
    return res;
  endfunction

  // Six-segment color wheel; a position on no segment holds.
  function automatic rgb_t wheel_step(input rgb_t w);
    rgb_t n;
    n = w;
    if (w.r == CH_MAX && w.g < CH_MAX && w.b == 8'd0)
      n.g = w.g + WHEEL_STEP;
    else if (w.r > 8'd0 && w.g == CH_MAX && w.b == 8'd0)
      n.r = w.r - WHEEL_STEP;
    else if (w.r == 8'd0 && w.g == CH_MAX && w.b < CH_MAX)
      n.b = w.b + WHEEL_STEP;
    else if (w.r == 8'd0 && w.g > 8'd0 && w.b == CH_MAX)
      n.g = w.g - WHEEL_STEP;
    else if (w.r < CH_MAX && w.g == 8'd0 && w.b == CH_MAX)
      n.r = w.r + WHEEL_STEP;
    else if (w.r == CH_MAX && w.g == 8'd0 && w.b > 8'd0)
      n.b = w.b - WHEEL_STEP;
    return n;
  endfunction

endpackage

### rtl/rgbrbc_if.sv
// Valid/ready channel interfaces for the event input and the drive result.
// Depends on rgbrbc_pkg for field widths.
interface rgbrbc_in_if import rgbrbc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [2:0]         mode;
  logic [COLOR_W-1:0] color;

  modport source (output valid, mode, color, input ready);
  modport sink   (input valid, mode, color, output ready);
endinterface

interface rgbrbc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_drive;
  logic [7:0] green_drive;
  logic [7:0] blue_drive;
  logic       rainbow_active;
  logic       blink_active;

  modport source (output valid, red_drive, green_drive, blue_drive, rainbow_active,
                  blink_active, input ready);
  modport sink   (input valid, red_drive, green_drive, blue_drive, rainbow_active,
                  blink_active, output ready);
endinterface

### rtl/rgb_led_rainbow_blink_controller.sv
// RGB LED controller: color wheel fader with blink, one event per transaction.
// Depends on rgbrbc_pkg and the channel interfaces in rgbrbc_if.sv.
// The result is registered: it is valid in the cycle after the event transaction.
// Throughput: one event per cycle while results are taken; the state update and result register load together.
// The result register frees as it is taken, so in_ready stays high unless a result stalls.
// Reset (synchronous, rst_n low): color and drives zero, wheel at red, modes off,
// periods 10 and 500 ticks.
module rgb_led_rainbow_blink_controller import rgbrbc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  rgbrbc_in_if.sink            in_chan,
  rgbrbc_out_if.source         out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PERIOD_W-1:0]  cfg_data
);

  period_t gradual_r, flicker_r;
  rgb_t    color_r, color_nxt;
  rgb_t    wheel_r, wheel_nxt;
  rgb_t    latch_r, latch_nxt;
  logic    rainbow_en_r, rainbow_en_nxt;
  logic    blink_en_r, blink_en_nxt;
  logic    phase_r, phase_nxt;
  cnt_t    rcnt_r, rcnt_nxt;
  cnt_t    bcnt_r, bcnt_nxt;
  logic    out_valid_r;
  logic    in_acc;
  mode_t   mode;
  cnt_step_t rstep, bstep;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign mode          = mode_t'(in_chan.mode);
  assign rstep         = count_step(rcnt_r, gradual_r);
  assign bstep         = count_step(bcnt_r, flicker_r);

  always_comb begin
    color_nxt      = color_r;
    wheel_nxt      = wheel_r;
    latch_nxt      = latch_r;
    rainbow_en_nxt = rainbow_en_r;
    blink_en_nxt   = blink_en_r;
    phase_nxt      = phase_r;
    rcnt_nxt       = rcnt_r;
    bcnt_nxt       = bcnt_r;
    case (mode)
      MODE_TICK: begin
        // rainbow step first, so a blink flip on the same tick latches the new color
        if (rainbow_en_r) begin
          rcnt_nxt = rstep.next;
          if (rstep.hit) begin
            wheel_nxt = wheel_step(wheel_r);
            color_nxt = wheel_nxt;
          end
        end
        if (blink_en_r) begin
          bcnt_nxt = bstep.next;
          if (bstep.hit) begin
            phase_nxt = !phase_r;
            latch_nxt = phase_nxt ? '0 : color_nxt;
          end
        end
      end
      MODE_SET_COLOR: color_nxt = rgb_t'(in_chan.color);
      MODE_RAINBOW: begin
        rainbow_en_nxt = !rainbow_en_r;
        if (!rainbow_en_r)
          rcnt_nxt = '0;
      end
      MODE_BLINK: begin
        blink_en_nxt = !blink_en_r;
        if (!blink_en_r)
          bcnt_nxt = '0;
      end
      MODE_ALL_OFF: begin
        color_nxt      = '0;
        rainbow_en_nxt = 1'b0;
        blink_en_nxt   = 1'b0;
      end
      default: ;
    endcase
    if (!blink_en_nxt)
      latch_nxt = color_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gradual_r    <= GRADUAL_RESET;
      flicker_r    <= FLICKER_RESET;
      color_r      <= '0;
      wheel_r      <= '{r: CH_MAX, g: 8'd0, b: 8'd0};
      latch_r      <= '0;
      rainbow_en_r <= 1'b0;
      blink_en_r   <= 1'b0;
      phase_r      <= 1'b0;
      rcnt_r       <= '0;
      bcnt_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_GRADUAL: gradual_r <= cfg_data;
          CFG_FLICKER: flicker_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_acc) begin
        color_r      <= color_nxt;
        wheel_r      <= wheel_nxt;
        latch_r      <= latch_nxt;
        rainbow_en_r <= rainbow_en_nxt;
        blink_en_r   <= blink_en_nxt;
        phase_r      <= phase_nxt;
        rcnt_r       <= rcnt_nxt;
        bcnt_r       <= bcnt_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  // result fields come straight from the state written by the last transaction
  assign out_chan.valid          = out_valid_r;
  assign out_chan.red_drive      = latch_r.r;
  assign out_chan.green_drive    = latch_r.g;
  assign out_chan.blue_drive     = latch_r.b;
  assign out_chan.rainbow_active = rainbow_en_r;
  assign out_chan.blink_active   = blink_en_r;

  a_all_off_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && mode == MODE_ALL_OFF |=> !rainbow_en_r && !blink_en_r && color_r == '0)
    else $error("all off did not clear modes and color");

  a_follow_color: assert property (@(posedge clk) disable iff (!rst_n)
    !blink_en_r |-> latch_r == color_r)
    else $error("drives do not follow color without blink");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_chan.ready |-> !in_acc)
    else $error("event taken while result stalled");

  a_color_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(color_r) && $stable(wheel_r) && $stable(latch_r))
    else $error("state changed without a transaction");

endmodule

### bench/tb_rgb_led_rainbow_blink_controller.sv
`timescale 1ns / 1ps
// Testbench for rgb_led_rainbow_blink_controller: random event streams with stalls on both
// channels, checked against a cycle-free color/blink predictor. Needs rgbrbc_pkg, the
// channel interfaces in rgbrbc_if.sv and the controller RTL.
module tb_rgb_led_rainbow_blink_controller import rgbrbc_pkg::*; ();

  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASES       = 8;
  localparam logic [7:0] HUE_STEP = 8'd5;

  localparam period_t GRADUAL_SET [PHASES] = '{16'd0, 16'd1, 16'd3, 16'd2,
                                               16'hFFFF, 16'd7, 16'd1, 16'hFFFF};
  localparam period_t FLICKER_SET [PHASES] = '{16'd0, 16'd2, 16'd5, 16'hFFFF,
                                               16'd1, 16'd4, 16'd0, 16'hFFFF};

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       rainbow;
    logic       blink;
  } drive_state_t;

  class led_drive_scoreboard;
    period_t      gradual, flicker;
    rgb_t         color, wheel, latch;
    bit           rainbow_on, blink_on, blanked;
    cnt_t         rainbow_cnt, blink_cnt;
    drive_state_t pending_drives[$];
    int           errors;

    function new();
      gradual     = 16'd10;
      flicker     = 16'd500;
      color       = '0;
      wheel       = {8'hFF, 8'h00, 8'h00};
      latch       = '0;
      rainbow_on  = 1'b0;
      blink_on    = 1'b0;
      blanked     = 1'b0;
      rainbow_cnt = '0;
      blink_cnt   = '0;
      errors      = 0;
    endfunction

    function void set_period(cfg_idx_t idx, period_t value);
      if (idx == CFG_GRADUAL) gradual = value;
      else flicker = value;
    endfunction

    // Period of zero behaves as one; counter overflow also ends the period.
    function bit period_elapsed(inout cnt_t cnt, input period_t period);
      logic [COUNTER_BITS:0] nxt;
      nxt = {1'b0, cnt} + 1'b1;
      if (nxt >= period || nxt[COUNTER_BITS]) begin
        cnt = '0;
        return 1'b1;
      end
      cnt = nxt[COUNTER_BITS-1:0];
      return 1'b0;
    endfunction

    function rgb_t next_wheel(rgb_t w);
      rgb_t n;
      n = w;
      if (w.r == 8'hFF && w.b == 8'h00 && w.g != 8'hFF) n.g = w.g + HUE_STEP;
      else if (w.g == 8'hFF && w.b == 8'h00 && w.r != 8'h00) n.r = w.r - HUE_STEP;
      else if (w.r == 8'h00 && w.g == 8'hFF && w.b != 8'hFF) n.b = w.b + HUE_STEP;
      else if (w.r == 8'h00 && w.b == 8'hFF && w.g != 8'h00) n.g = w.g - HUE_STEP;
      else if (w.g == 8'h00 && w.b == 8'hFF && w.r != 8'hFF) n.r = w.r + HUE_STEP;
      else if (w.r == 8'hFF && w.g == 8'h00 && w.b != 8'h00) n.b = w.b - HUE_STEP;
      return n;
    endfunction

    function void note_event(logic [2:0] code, logic [23:0] rgb);
      case (code)
        MODE_TICK: begin
          // wheel step lands in the color before the blink phase looks at it
          if (rainbow_on) begin
            if (period_elapsed(rainbow_cnt, gradual)) begin
              wheel = next_wheel(wheel);
              color = wheel;
            end
          end
          if (blink_on) begin
            if (period_elapsed(blink_cnt, flicker)) begin
              blanked = !blanked;
              latch   = blanked ? rgb_t'('0) : color;
            end
          end
        end
        MODE_SET_COLOR: color = rgb;
        MODE_RAINBOW: begin
          rainbow_on = !rainbow_on;
          if (rainbow_on) rainbow_cnt = '0;
        end
        MODE_BLINK: begin
          blink_on = !blink_on;
          if (blink_on) blink_cnt = '0;
        end
        MODE_ALL_OFF: begin
          color      = '0;
          rainbow_on = 1'b0;
          blink_on   = 1'b0;
        end
        default: ;
      endcase
      if (!blink_on) latch = color;
      pending_drives.push_back({latch, rainbow_on, blink_on});
    endfunction

    function void check_drive(drive_state_t got);
      drive_state_t want;
      if (pending_drives.size() == 0) begin
        $error("drive result with no event transaction pending");
        errors++;
        return;
      end
      want = pending_drives.pop_front();
      if (got.red != want.red) begin
        $error("red_drive: expected %0h, got %0h", want.red, got.red);
        errors++;
      end
      if (got.green != want.green) begin
        $error("green_drive: expected %0h, got %0h", want.green, got.green);
        errors++;
      end
      if (got.blue != want.blue) begin
        $error("blue_drive: expected %0h, got %0h", want.blue, got.blue);
        errors++;
      end
      if (got.rainbow != want.rainbow) begin
        $error("rainbow_active: expected %0b, got %0b", want.rainbow, got.rainbow);
        errors++;
      end
      if (got.blink != want.blink) begin
        $error("blink_active: expected %0b, got %0b", want.blink, got.blink);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PERIOD_W-1:0]  cfg_data;
  bit                   calm;
  int                   idle_cycles;
  led_drive_scoreboard  sb;

  rgbrbc_in_if  in_chan ();
  rgbrbc_out_if out_chan ();

  rgb_led_rainbow_blink_controller i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    int hold;
    hold = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_chan.ready <= 1'b0;
        hold--;
      end else begin
        out_chan.ready <= 1'b1;
        if (!calm) hold = pick_gap();
      end
    end
  end

  // Transaction monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) sb.note_event(in_chan.mode, in_chan.color);
      if (out_chan.valid && out_chan.ready)
        sb.check_drive({out_chan.red_drive, out_chan.green_drive, out_chan.blue_drive,
                        out_chan.rainbow_active, out_chan.blink_active});
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic send_event(logic [2:0] code, logic [23:0] rgb);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.mode  <= code;
    in_chan.color <= rgb;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_drives();
    in_chan.valid <= 1'b0;
    while (sb.pending_drives.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_periods(period_t gradual, period_t flicker);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_GRADUAL;
    cfg_data  <= gradual;
    @(negedge clk);
    cfg_index <= CFG_FLICKER;
    cfg_data  <= flicker;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_period(CFG_GRADUAL, gradual);
    sb.set_period(CFG_FLICKER, flicker);
  endtask

  task automatic random_event(int tick_pct, bit keep_rainbow);
    int          roll;
    logic [2:0]  code;
    logic [23:0] rgb;
    rgb  = 24'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < tick_pct) begin
      code = MODE_TICK;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 40) code = MODE_SET_COLOR;
      else if (roll < 60) code = MODE_BLINK;
      else if (roll < 80) code = keep_rainbow ? MODE_SET_COLOR : MODE_RAINBOW;
      else if (roll < 90) code = keep_rainbow ? MODE_BLINK : MODE_ALL_OFF;
      else code = 3'(MODE_ALL_OFF) + 3'($urandom_range(1, 3));
    end
    send_event(code, rgb);
  endtask

  initial begin
    logic [2:0] spare;
    int         phase_idx;
    sb             = new();
    calm           = 1'b1;
    idle_cycles    = 0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_GRADUAL;
    cfg_data       = '0;
    in_chan.valid  = 1'b0;
    in_chan.mode   = MODE_TICK;
    in_chan.color  = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset periods: color extremes, spare mode codes, toggles and all off
    send_event(MODE_TICK, 24'h000000);
    send_event(MODE_SET_COLOR, 24'hFFFFFF);
    send_event(MODE_SET_COLOR, 24'h000000);
    send_event(MODE_SET_COLOR, 24'h5AA5C3);
    spare = MODE_ALL_OFF;
    repeat (3) begin
      spare++;
      send_event(spare, 24'hFFFFFF);
    end
    send_event(MODE_RAINBOW, 24'h000000);
    send_event(MODE_BLINK, 24'h000000);
    send_event(MODE_SET_COLOR, 24'h123456);   // drives hold until the first flip
    send_event(MODE_ALL_OFF, 24'hFFFFFF);

    // Shortest periods: wheel step and blink flip on the same tick
    drain_drives();
    set_periods(16'd1, 16'd1);
    send_event(MODE_RAINBOW, 24'h000000);
    send_event(MODE_TICK, 24'h000000);
    send_event(MODE_TICK, 24'h000000);
    send_event(MODE_BLINK, 24'h000000);
    send_event(MODE_TICK, 24'h000000);
    send_event(MODE_TICK, 24'h000000);
    send_event(MODE_SET_COLOR, 24'h00FF00);
    send_event(MODE_TICK, 24'h000000);
    send_event(MODE_BLINK, 24'h000000);
    send_event(MODE_RAINBOW, 24'h000000);
    send_event(MODE_TICK, 24'h000000);
    send_event(MODE_RAINBOW, 24'h000000);
    send_event(MODE_ALL_OFF, 24'h000000);

    for (phase_idx = 0; phase_idx < PHASES; phase_idx++) begin
      drain_drives();
      set_periods(GRADUAL_SET[phase_idx], FLICKER_SET[phase_idx]);
      calm = ($urandom_range(0, 3) == 0);
      repeat (60) random_event(70, 1'b0);
    end

    // Long rainbow run so the wheel goes through all six segments
    drain_drives();
    set_periods(16'd0, 16'd3);
    calm = 1'b0;
    if (!sb.rainbow_on) send_event(MODE_RAINBOW, 24'h000000);
    repeat (320) random_event(92, 1'b1);

    drain_drives();
    if (sb.errors == 0 && sb.pending_drives.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
